/* sv/postfix_expression_evaluator_top_assert.svh */
// Assertion macros used by the evaluator top level.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define PEF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pef_pkg.sv */
package pef_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_STACK_DEPTH = 128;
  localparam int CMDQ_DEPTH      = 2;
  localparam int DIV_STEPS       = DATA_W;

  // ASCII characters of interest
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef logic [2:0] op_t;
  localparam op_t OP_NOP  = 3'd0;
  localparam op_t OP_PUSH = 3'd1;
  localparam op_t OP_ADD  = 3'd2;
  localparam op_t OP_SUB  = 3'd3;
  localparam op_t OP_MUL  = 3'd4;
  localparam op_t OP_DIV  = 3'd5;
  localparam op_t OP_BAD  = 3'd6;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_OVERFLOW = 3'd1;
  localparam err_t ERR_EMPTY    = 3'd2;
  localparam err_t ERR_BAD_OP   = 3'd3;
  localparam err_t ERR_DIV_ZERO = 3'd4;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/pef_front.sv */
module pef_front import pef_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_symbol,
  input  logic       in_final_symbol,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           q_r [CMDQ_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  cmd_t           cls;
  logic [7:0]     digit_full;
  logic           wr_en;
  logic           rd_en;

  // Classify the incoming character
  assign digit_full = in_symbol - CH_ZERO;

  always_comb begin
    cls.digit = digit_full[3:0];
    cls.last  = in_final_symbol;
    unique case (in_symbol) inside
      CH_COMMA:          cls.op = OP_NOP;
      [CH_ZERO:CH_NINE]: cls.op = OP_PUSH;
      CH_PLUS:           cls.op = OP_ADD;
      CH_MINUS:          cls.op = OP_SUB;
      CH_STAR:           cls.op = OP_MUL;
      CH_SLASH:          cls.op = OP_DIV;
      default:           cls.op = OP_BAD;
    endcase
  end

  assign full      = (count_r == QCW'(CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* sv/pef_div.sv */
module pef_div import pef_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DCW = $clog2(DIV_STEPS);

  logic              busy_r;
  logic              done_r;
  logic [DCW-1:0]    cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] den_r;
  logic              neg_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign mag_a = req.dividend[DATA_W-1] ? ('0 - req.dividend) : req.dividend;
  assign mag_b = req.divisor[DATA_W-1]  ? ('0 - req.divisor)  : req.divisor;

  // One restoring step per cycle
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = !diff[DATA_W];

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? ('0 - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= mag_a;
      den_r <= mag_b;
      neg_r <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
  end

endmodule

/* sv/pef_exec.sv */
module pef_exec import pef_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] res_value,
  output err_t              res_error
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_POP_R   = 4'd1;
  localparam logic [3:0] ST_POP_L   = 4'd2;
  localparam logic [3:0] ST_TAKE_L  = 4'd3;
  localparam logic [3:0] ST_EXEC    = 4'd4;
  localparam logic [3:0] ST_DIV     = 4'd5;
  localparam logic [3:0] ST_PUSH    = 4'd6;
  localparam logic [3:0] ST_FIN_POP = 4'd7;
  localparam logic [3:0] ST_FIN_OUT = 4'd8;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  err_t              err_r, err_nxt;
  op_t               op_r, op_nxt;
  logic              last_r, last_nxt;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] right_r, right_nxt;
  logic [DATA_W-1:0] left_r, left_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  err_t              out_err_r, out_err_nxt;
  logic [DATA_W-1:0] rd_data_r;

  logic              push_en;
  logic [DATA_W-1:0] push_data;
  logic              pop_en;
  logic              clear;
  err_t              note;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     cnt_dec;
  logic              out_free;
  logic [DATA_W-1:0] popped;

  assign cnt_dec  = count_r - 1'b1;
  assign out_free = !out_valid_r || pop;
  assign popped   = hit_r ? rd_data_r : '0;
  assign wr_addr  = count_r[AW-1:0];
  assign rd_addr  = cnt_dec[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    cmd_pop       = 1'b0;
    push_en       = 1'b0;
    push_data     = res_r;
    pop_en        = 1'b0;
    clear         = 1'b0;
    note          = ERR_NONE;
    div_req.start    = 1'b0;
    div_req.dividend = left_r;
    div_req.divisor  = right_r;

    // Drop the result beat once taken
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          op_nxt   = cmd.op;
          last_nxt = cmd.last;
          if (cmd.op == OP_PUSH) begin
            push_en   = 1'b1;
            push_data = {{(DATA_W-4){1'b0}}, cmd.digit};
            state_nxt = cmd.last ? ST_FIN_POP : ST_IDLE;
          end else if (cmd.op == OP_NOP) begin
            state_nxt = cmd.last ? ST_FIN_POP : ST_IDLE;
          end else begin
            state_nxt = ST_POP_R;
          end
        end
      end
      ST_POP_R: begin
        pop_en    = 1'b1;
        state_nxt = ST_POP_L;
      end
      ST_POP_L: begin
        pop_en    = 1'b1;
        right_nxt = popped;
        state_nxt = ST_TAKE_L;
      end
      ST_TAKE_L: begin
        left_nxt  = popped;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_PUSH;
        unique case (op_r)
          OP_ADD: res_nxt = left_r + right_r;
          OP_SUB: res_nxt = left_r - right_r;
          OP_MUL: res_nxt = left_r * right_r;
          OP_DIV: begin
            if (right_r == '0) begin
              note    = ERR_DIV_ZERO;
              res_nxt = '0;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          default: begin
            note    = ERR_BAD_OP;
            res_nxt = '0;
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push_en   = 1'b1;
        state_nxt = last_r ? ST_FIN_POP : ST_IDLE;
      end
      ST_FIN_POP: begin
        pop_en    = 1'b1;
        state_nxt = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        // Hold until the result register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = popped;
          out_err_nxt   = err_r;
          clear         = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Stack push: drop on a full stack
    wr_en = 1'b0;
    if (push_en) begin
      if (count_r == CW'(STACK_DEPTH)) begin
        note = ERR_OVERFLOW;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end

    // Stack pop: an empty stack reads as zero
    rd_en = 1'b0;
    if (pop_en) begin
      if (count_r == '0) begin
        note    = ERR_EMPTY;
        hit_nxt = 1'b0;
      end else begin
        rd_en     = 1'b1;
        hit_nxt   = 1'b1;
        count_nxt = cnt_dec;
      end
    end

    // Keep only the first error
    if (note != ERR_NONE && err_r == ERR_NONE) begin
      err_nxt = note;
    end

    if (clear) begin
      count_nxt = '0;
      err_nxt   = ERR_NONE;
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operands and result payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    hit_r       <= hit_nxt;
    right_r     <= right_nxt;
    left_r      <= left_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign empty     = !out_valid_r;
  assign res_value = out_value_r;
  assign res_error = out_err_r;

endmodule

/* sv/postfix_expression_evaluator_top.sv */
// Postfix expression evaluator: one ASCII character per input beat.
// Input side is a queue: drive in_symbol/in_final_symbol with push; the beat
// is taken when push is high and full is low. Commas are skipped, digits are
// pushed, anything else pops two values and pushes the result of + - * /.
// A beat with in_final_symbol set ends the expression: the top is popped and
// one result beat (out_value, out_error_code) appears; other beats give none.
// Result side is a queue: a result waits on the out_ ports while empty is low
// and is taken when pop is high. The result register is one deep; while it
// is held, the evaluator stalls and up to two more input beats queue up
// before full rises.
// Stack unit: an operator pops right, then left, executes and pushes; / waits
// on the divider (one quotient bit per cycle); a final beat pops the top and
// outputs it. The command queue is registered in front of the stack unit.
// Errors: 1 push onto full stack, 2 pop of empty stack, 3 bad operator,
// 4 divide by zero; only the first per expression is reported.
// Reset (rst_n low, synchronous) empties both queues and the stack and
// clears the error; no reset pass is needed, the block is ready right after.
`include "postfix_expression_evaluator_top_assert.svh"

module postfix_expression_evaluator_top import pef_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_symbol,
  input  logic               in_final_symbol,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_error_code
);

  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DATA_W-1:0] res_value;
  err_t              res_error;

  pef_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_symbol       (in_symbol),
    .in_final_symbol (in_final_symbol),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  pef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pef_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .empty     (empty),
    .pop       (pop),
    .res_value (res_value),
    .res_error (res_error)
  );

  assign out_value      = $signed(res_value);
  assign out_error_code = res_error;

  // Consistency checks between front, stack unit and divider
  `PEF_ASSERT_SAME(a_cmd_pop_valid, cmd_pop, cmd_valid, "command queue popped while empty")
  `PEF_ASSERT_SAME(a_full_has_cmd, full, cmd_valid, "queue full but no command offered")
  `PEF_ASSERT_SAME(a_div_start_ok, div_req.start, !div_rsp.busy && div_req.divisor != '0, "divider started while busy or by zero")
  `PEF_ASSERT_NEXT(a_div_not_instant, div_req.start, !div_rsp.done, "divider finished right after start")

endmodule

/* dv/tb_top.sv */
module tb_top import pef_pkg::*; ();

  typedef logic [7:0] sym_q_t [$];

  // Tracks the evaluator's stack and first error and holds the answers still due
  class rpn_answer_board;
    typedef struct {
      logic [31:0] value;
      err_t        code;
    } answer_t;

    logic [31:0] stack_mem [DEF_STACK_DEPTH];
    int unsigned depth;
    err_t        first_err;
    answer_t     pending [$];
    int unsigned checked;
    int unsigned bad_answers;
    int unsigned code_hits [8];

    function new();
      depth       = 0;
      first_err   = ERR_NONE;
      checked     = 0;
      bad_answers = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    // Keep only the first error of an expression
    function void flag(err_t code);
      if (first_err == ERR_NONE) first_err = code;
    endfunction

    function void push_val(logic [31:0] v);
      if (depth >= DEF_STACK_DEPTH) begin
        flag(ERR_OVERFLOW);
      end else begin
        stack_mem[depth] = v;
        depth++;
      end
    endfunction

    function logic [31:0] pop_val();
      if (depth == 0) begin
        flag(ERR_EMPTY);
        return '0;
      end
      depth--;
      return stack_mem[depth];
    endfunction

    // Truncate toward zero; the most negative value over -1 wraps to itself
    function logic [31:0] quotient(logic [31:0] lhs, logic [31:0] rhs);
      logic [31:0] mag_l, mag_r, q;
      mag_l = lhs[31] ? -lhs : lhs;
      mag_r = rhs[31] ? -rhs : rhs;
      q     = mag_l / mag_r;
      return (lhs[31] ^ rhs[31]) ? -q : q;
    endfunction

    // Apply one accepted symbol beat; a final beat queues the expected answer
    function void note_symbol(logic [7:0] sym, logic fin);
      logic [31:0] rhs, lhs, res;
      answer_t     ans;
      if (sym != CH_COMMA) begin
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
          push_val(32'(sym - CH_ZERO));
        end else begin
          rhs = pop_val();
          lhs = pop_val();
          res = '0;
          case (sym)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            CH_SLASH: begin
              if (rhs == '0) flag(ERR_DIV_ZERO);
              else res = quotient(lhs, rhs);
            end
            default:  flag(ERR_BAD_OP);
          endcase
          push_val(res);
        end
      end
      if (fin) begin
        ans.value = pop_val();
        ans.code  = first_err;
        pending.push_back(ans);
        depth     = 0;
        first_err = ERR_NONE;
      end
    endfunction

    // Compare one accepted answer beat against the oldest expected answer
    function void check_answer(logic [31:0] v, err_t c);
      answer_t want;
      checked++;
      if (pending.size() == 0) begin
        bad_answers++;
        if (bad_answers <= 10)
          $display("unexpected answer: value %0d code %0d", $signed(v), c);
        return;
      end
      want = pending.pop_front();
      code_hits[want.code]++;
      if (v !== want.value || c !== want.code) begin
        bad_answers++;
        if (bad_answers <= 10)
          $display("bad answer %0d: value exp %0d got %0d, code exp %0d got %0d",
                   checked, $signed(want.value), $signed(v), want.code, c);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_symbol;
  logic               in_final_symbol;
  logic               empty;
  logic               pop;
  logic signed [31:0] out_value;
  logic [2:0]         out_error_code;

  bit                 no_idle = 1'b0;
  int unsigned        beats_sent = 0;
  rpn_answer_board    answers = new();

  postfix_expression_evaluator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_symbol       (in_symbol),
    .in_final_symbol (in_final_symbol),
    .empty           (empty),
    .pop             (pop),
    .out_value       (out_value),
    .out_error_code  (out_error_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Multiplication is weighted up so values grow large and wrap
  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_SLASH;
      default: return CH_STAR;
    endcase
  endfunction

  // Build a well-formed expression of at least len symbols with random content
  function automatic void build_wellformed(int unsigned len, output sym_q_t q);
    int unsigned d;
    d = 0;
    q.delete();
    while (q.size() < len || d != 1) begin
      if (d < 2 || (q.size() < len && $urandom_range(0, 99) < 55)) begin
        q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        d++;
      end else begin
        q.push_back(pick_op());
        d--;
      end
      if ($urandom_range(0, 99) < 8) q.push_back(CH_COMMA);
    end
  endfunction

  // Offer one input beat, idling first at random, and hold it until taken
  task automatic send_beat(input logic [7:0] sym, input logic fin);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_symbol       <= sym;
    in_final_symbol <= fin;
    do @(posedge clk); while (full);
    answers.note_symbol(sym, fin);
    beats_sent++;
  endtask

  // Send a whole expression, marking its last symbol final
  task automatic send_expr(input sym_q_t q);
    foreach (q[i]) send_beat(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    sym_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_expr(q);
  endtask

  // Take answer beats, stalling at random outside the no-idle stretch
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) answers.check_answer(out_value, out_error_code);
      pop <= (no_idle || $urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    sym_q_t      q;
    int unsigned pick, k, ovf_runs;
    ovf_runs        = 0;
    rst_n           <= 1'b0;
    push            <= 1'b0;
    in_symbol       <= '0;
    in_final_symbol <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each operator, negative division, final on a comma,
    // divide by zero, empty pops, unknown operators at both byte extremes
    send_text("34+");
    send_text("93-");
    send_text("27*");
    send_text("09-4/");
    send_text("9,");
    send_text("50/");
    send_text("+");
    send_beat(CH_ZERO + 8'd1, 1'b0);
    send_beat(CH_ZERO + 8'd2, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);

    // Random: mostly well-formed expressions, plus broken ones and noise
    while (beats_sent < 1150) begin
      no_idle = (beats_sent >= 500 && beats_sent < 700);
      pick    = $urandom_range(0, 99);
      q.delete();
      if (ovf_runs == 0 || pick >= 99) begin
        // push past the stack depth, then fold a few values
        ovf_runs++;
        k = DEF_STACK_DEPTH + $urandom_range(1, 3);
        repeat (k) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) q.push_back(CH_PLUS);
        send_expr(q);
      end else if (pick < 64) begin
        build_wellformed((pick < 4) ? $urandom_range(40, 90) : $urandom_range(1, 14), q);
        send_expr(q);
      end else if (pick < 77) begin
        // drop a symbol, insert a random byte or add a stray operator
        build_wellformed($urandom_range(2, 12), q);
        k = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 2))
          0:       q.delete(k);
          1:       q.insert(k, 8'($urandom_range(0, 255)));
          default: q.push_back(pick_op());
        endcase
        if (q.size() != 0) send_expr(q);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        // build 2^31 (most negative) by repeated multiply, or wrap to zero with one more, then divide it
        k = ($urandom_range(0, 3) == 0) ? 10 : 9;
        q.push_back(CH_ZERO + 8'd8);
        repeat (k) begin
          q.push_back(CH_ZERO + 8'd8);
          q.push_back(CH_STAR);
        end
        q.push_back(CH_ZERO + 8'd2);
        q.push_back(CH_STAR);
        if ($urandom_range(0, 3) != 0) begin
          q.push_back(CH_ZERO);
          q.push_back(CH_ZERO + 8'd1);
          q.push_back(CH_MINUS);
        end else begin
          q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        q.push_back(CH_SLASH);
        send_expr(q);
      end
    end
    push    <= 1'b0;
    no_idle = 1'b0;

    // Drain the answers, then allow for work still in flight
    while (answers.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("run covered %0d input beats, %0d answers checked, %0d overflow runs",
             beats_sent, answers.checked, ovf_runs);
    $display("first errors: none %0d, ovf %0d, empty %0d, bad op %0d, div0 %0d; mismatches %0d",
             answers.code_hits[ERR_NONE], answers.code_hits[ERR_OVERFLOW],
             answers.code_hits[ERR_EMPTY], answers.code_hits[ERR_BAD_OP],
             answers.code_hits[ERR_DIV_ZERO], answers.bad_answers);
    if (answers.bad_answers == 0 && answers.pending.size() == 0) begin
      $display("postfix_expression_evaluator_top: match");
    end else begin
      $display("postfix_expression_evaluator_top: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("postfix_expression_evaluator_top: mismatch");
    $finish;
  end

endmodule
